// ===== hdl/percent_decoder_assert.svh =====
// Assertion macros used by the percent decoder top level.
`ifndef PERCENT_DECODER_ASSERT_SVH
`define PERCENT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising edge outside reset.
`define PCTD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define PCTD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PCTD_ASSERT(label, clk, rst, prop, msg)
`define PCTD_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== hdl/pctd_pkg.sv =====
// Types, constants and helpers of the percent decoder.
package pctd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;

   // Up to three output bytes produced by one input transaction.
   localparam int unsigned MAX_OUT = 3;

   // One queued output command: bytes go out in order data[0], data[1], data[2].
   typedef struct packed {
      logic                     last;   // tlast on the final byte of the command
      logic [1:0]               count;  // number of bytes, 1 to 3
      logic [MAX_OUT-1:0][7:0]  data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_type;

   // Classify an ASCII character as a hex digit and give its value.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid  = 1'b0;
      h.nibble = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.valid  = 1'b1;
         h.nibble = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.valid  = 1'b1;
         h.nibble = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

// ===== hdl/pctd_front.sv =====
// Front end: tracks held escape bytes and turns each input byte into an output command.
module pctd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              is_last,
   output logic              push,
   output pctd_pkg::cmd_type cmd
);
   import pctd_pkg::*;

   typedef enum logic [2:0] {
      PEND_NONE  = 3'b001,
      PEND_PCT   = 3'b010,
      PEND_DIGIT = 3'b100
   } pend_type;

   pend_type   pend_ff, pend_in;
   logic [7:0] digit_ff, digit_in;
   hex_type    hex_in_byte;
   hex_type    hex_held;

   assign hex_in_byte = hex_decode(in_byte);
   assign hex_held    = hex_decode(digit_ff);

   always_comb begin
      pend_in     = PEND_NONE;
      digit_in    = digit_ff;
      cmd.last    = is_last;
      cmd.count   = 2'd1;
      cmd.data[0] = in_byte;
      cmd.data[1] = in_byte;
      cmd.data[2] = in_byte;
      unique case (pend_ff)
         PEND_PCT: begin
            if (is_last) begin
               cmd.count   = 2'd2;
               cmd.data[0] = PCT_CHAR;
            end else if (hex_in_byte.valid) begin
               cmd.count = 2'd0;
               digit_in  = in_byte;
               pend_in   = PEND_DIGIT;
            end else if (in_byte == PCT_CHAR) begin
               // emit the old '%', hold the new one
               cmd.data[0] = PCT_CHAR;
               pend_in     = PEND_PCT;
            end else begin
               cmd.count   = 2'd2;
               cmd.data[0] = PCT_CHAR;
            end
         end
         PEND_DIGIT: begin
            if (hex_in_byte.valid) begin
               cmd.data[0] = {hex_held.nibble, hex_in_byte.nibble};
            end else begin
               cmd.data[0] = PCT_CHAR;
               cmd.data[1] = digit_ff;
               if (in_byte == PCT_CHAR && !is_last) begin
                  cmd.count = 2'd2;
                  pend_in   = PEND_PCT;
               end else begin
                  cmd.count = 2'd3;
               end
            end
         end
         default: begin
            if (in_byte == PCT_CHAR && !is_last) begin
               cmd.count = 2'd0;
               pend_in   = PEND_PCT;
            end
         end
      endcase
   end

   assign push = accept && (cmd.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
      end else if (accept) begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         digit_ff <= digit_in;
      end
   end

endmodule

// ===== hdl/pctd_queue.sv =====
// Command queue between the front end and the output serializer.
module pctd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pctd_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output pctd_pkg::cmd_type          head_cmd,
   output pctd_pkg::queue_status_type status
);
   import pctd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign head_cmd     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/pctd_back.sv =====
// Back end: serializes queued commands into output bytes through an output register.
module pctd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  pctd_pkg::cmd_type          head_cmd,
   input  pctd_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast
);
   import pctd_pkg::*;

   logic       cur_valid_ff, cur_valid_in;
   cmd_type    cur_ff;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;
   logic       load_rsp;
   logic       at_end;
   logic       finish;

   assign load_rsp = cur_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign at_end   = (idx_ff == cur_ff.count - 2'd1);
   assign finish   = load_rsp && at_end;
   assign pop      = (!cur_valid_ff || finish) && !status.empty;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else if (load_rsp) begin
         idx_in = idx_ff + 2'd1;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_cmd;
      end
      if (load_rsp) begin
         rsp_data_ff <= cur_ff.data[idx_ff];
         rsp_last_ff <= at_end && cur_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/percent_decoder.sv =====
// Percent decoder top level: front end, command queue and output serializer.
//
// Streaming URL percent-escape decoder. Each request transaction carries one byte of an
// encoded string, with tlast on the byte that ends the string. "%XY" with two hex digits
// (either case) becomes the byte 0xXY; a broken escape is passed through as is and the bytes
// after the '%' are looked at again, so a later '%' can open a fresh escape. On the last
// byte every held byte is flushed unchanged unless it completes an escape, and the final
// response byte of the string carries tlast. One request transaction yields zero to three
// response transactions. The front end accepts one byte per cycle as long as the command
// queue (QUEUE_DEPTH entries) has room; the output serializer drains one byte per cycle, so
// the sustained rate is one request per cycle while each request yields at most one byte,
// and the response port (one byte per cycle) sets the pace otherwise. An accepted request
// goes through the queue, the serializer's command register and the output register.
`include "percent_decoder_assert.svh"

module percent_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // is_last
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);
   import pctd_pkg::*;

   logic             req_accept;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type status;

   // Take a new byte whenever the queue can hold its command.
   assign req_tready = !status.full;
   assign req_accept = req_tvalid && req_tready;

   // Classify the byte against the held escape state and build its command.
   pctd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .in_byte (req_tdata),
      .is_last (req_tlast),
      .push    (push),
      .cmd     (push_cmd)
   );

   // Decouple classification from the output port.
   pctd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (status)
   );

   // Drain commands one byte per response transaction.
   pctd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A command is never written into a full queue.
   `PCTD_ASSERT_NEVER(a_no_push_full, clock, reset, push && status.full, "push into full queue")
   // The serializer never takes a command from an empty queue.
   `PCTD_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && status.empty, "pop from empty queue")
   // A push without a pop fills the queue by one entry.
   `PCTD_ASSERT(a_push_fills, clock, reset, (push && !pop) |=> !status.empty, "queue lost an entry")

endmodule

// ===== tb/percent_decoder_tb.sv =====
// Self-checking testbench for the percent decoder: directed and random strings vs. a predictor.
module percent_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pctd_pkg::*;

   // Generous cycle budget. A slow request yields three bytes out, each behind a
   // receiver stall, plus a sender gap.
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Quiet cycles after the last expected byte to catch stray output.
   localparam int unsigned SETTLE_CYCLES = 10;

   // Non-hex characters that sit right next to the digit ranges.
   localparam logic [7:0] NEAR_HEX [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_byte_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tlast  = 1'b0;    // is_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;            // out_last

   // Bytes the decoder must still produce, oldest first.
   decoded_byte_type decoded_queue[$];

   // Predictor copy of the escape state.
   logic [1:0]  held_count = 2'd0;   // 0 nothing, 1 '%', 2 '%' and a digit
   logic [7:0]  held_digit = 8'h00;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_on     = 1'b1;  // random gaps and stalls on both sides

   percent_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Append one byte the decoder must produce.
   task automatic expect_byte(input logic [7:0] b, input logic last);
      decoded_byte_type item;
      item.data     = b;
      item.last     = last;
      decoded_queue = {decoded_queue, item};
   endtask

   // Return {is hex, nibble value} for an ASCII character.
   function automatic logic [4:0] hex_lookup(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      return 5'd0;
   endfunction

   // Treat a byte as if nothing were held: open an escape or pass it on.
   task automatic take_fresh(input logic [7:0] b, input logic last);
      if (b == PCT_CHAR && !last) begin
         held_count = 2'd1;
      end else begin
         held_count = 2'd0;
         expect_byte(b, last);
      end
   endtask

   // Advance the predictor by one accepted request and queue the bytes it yields.
   task automatic predict_decoded(input logic [7:0] b, input logic last);
      logic [4:0] first_hex;
      logic [4:0] this_hex;
      first_hex = hex_lookup(held_digit);
      this_hex  = hex_lookup(b);
      case (held_count)
         2'd1: begin
            if (last) begin
               // escape cut by end of string: flush '%' and the byte
               expect_byte(PCT_CHAR, 1'b0);
               expect_byte(b, 1'b1);
               held_count = 2'd0;
            end else if (this_hex[4]) begin
               held_digit = b;
               held_count = 2'd2;
            end else begin
               // bad first character: drop the escape, look at the byte again
               expect_byte(PCT_CHAR, 1'b0);
               take_fresh(b, 1'b0);
            end
         end
         2'd2: begin
            if (this_hex[4]) begin
               expect_byte({first_hex[3:0], this_hex[3:0]}, last);
               held_count = 2'd0;
            end else begin
               // bad second character: flush '%' and the digit unchanged
               expect_byte(PCT_CHAR, 1'b0);
               expect_byte(held_digit, 1'b0);
               take_fresh(b, last);
            end
         end
         default: take_fresh(b, last);
      endcase
   endtask

   // Drive one request transaction and hold it until accepted.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_decoded(b, last);
   endtask

   // Drop the request and wait on a clock edge with the channel idle.
   task automatic pause_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Send a whole string, tlast on its final byte.
   task automatic send_string(input logic [7:0] text[$]);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   task automatic wait_for_drain();
      while (decoded_queue.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [3:0] v;
      v = 4'($urandom_range(0, 15));
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   // A character that breaks an escape: range neighbors, '%' or anything.
   function automatic logic [7:0] random_breaker_char();
      case ($urandom_range(0, 3))
         0, 1:    return NEAR_HEX[$urandom_range(0, 5)];
         2:       return PCT_CHAR;
         default: return 8'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_valid_escapes();
      send_string('{PCT_CHAR, "4", "1"});
      send_string('{PCT_CHAR, "f", "F"});
      send_string('{PCT_CHAR, "0", "0", PCT_CHAR, "9", "a"});
   endtask

   task automatic test_single_bytes();
      send_string('{8'h00});
      send_string('{8'hFF});
   endtask

   task automatic test_cut_escapes();
      send_string('{PCT_CHAR});
      send_string('{PCT_CHAR, "9"});
      send_string('{"x", PCT_CHAR});
   endtask

   task automatic test_bad_first_char();
      // a second '%' reopens the escape
      send_string('{PCT_CHAR, PCT_CHAR, "3", "0"});
      send_string('{PCT_CHAR, "g", "z"});
   endtask

   task automatic test_bad_second_char();
      send_string('{PCT_CHAR, "a", "@", PCT_CHAR});
      send_string('{PCT_CHAR, "4", PCT_CHAR});
   endtask

   // Random strings of well-formed escapes with random content, broken escapes and plain bytes.
   task automatic test_random_strings(input int unsigned item_goal);
      logic [7:0]  text[$];
      int unsigned sent;
      sent = 0;
      while (sent < item_goal) begin
         text.delete();
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: text = {text, PCT_CHAR, random_hex_char(), random_hex_char()};
               4, 5:       text = {text, 8'($urandom)};
               6:          text = {text, PCT_CHAR, random_breaker_char()};
               7:          text = {text, PCT_CHAR, random_hex_char(), random_breaker_char()};
               8:          text = {text, PCT_CHAR};
               default:    text = {text, random_hex_char()};
            endcase
         end
         send_string(text);
         sent += text.size();
      end
   endtask

   // Full rate on both sides: no gaps, no stalls.
   task automatic test_back_to_back();
      idle_on = 1'b0;
      test_random_strings(40);
      idle_on = 1'b1;
   endtask

   // Stop mid-escape until every byte is out, then finish the escape.
   task automatic test_drain_pause();
      send_byte(PCT_CHAR, 1'b0);
      send_byte("4", 1'b0);
      pause_sender();
      wait_for_drain();
      send_string('{"1"});
      pause_sender();
      wait_for_drain();
   endtask

   // ------------------------------------------------------------ receiver

   // Stall rsp_tready at random and check every response transaction.
   initial begin
      int unsigned      stall;
      decoded_byte_type want;
      wait (!reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (decoded_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %b", rsp_tdata, rsp_tlast));
         end else begin
            want = decoded_queue.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch($sformatf("byte %02h, want %02h", rsp_tdata, want.data));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("tlast %b, want %b on byte %02h",
                                         rsp_tlast, want.last, want.data));
         end
      end
   end

   // ------------------------------------------------------------- sequence

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_valid_escapes();
      test_single_bytes();
      test_cut_escapes();
      test_bad_first_char();
      test_bad_second_char();
      test_random_strings(120);
      test_back_to_back();
      test_drain_pause();
      test_random_strings(70);

      pause_sender();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
